/* sv/integer_alu_64_top_assert.svh */
// Assertion macros for the integer ALU checker
`ifndef INTEGER_ALU_64_TOP_ASSERT_SVH
`define INTEGER_ALU_64_TOP_ASSERT_SVH
// check an implication on every clock edge outside reset
`define ALU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// check a next-cycle implication outside reset
`define ALU_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* sv/ia64_pkg.sv */
// Package: shared constants, commands and status codes of the integer ALU
package ia64_pkg;
   localparam int DW = 64;
   localparam int SW = 6;
   localparam int DIV_STEPS = 4;  // quotient bits per divider stage
   localparam int DIV_STAGES = DW / DIV_STEPS;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
      CMD_MOD = 4'd4, CMD_SHL = 4'd5, CMD_SHR = 4'd6, CMD_AND = 4'd7,
      CMD_OR = 4'd8, CMD_XOR = 4'd9, CMD_ROL = 4'd10, CMD_ROR = 4'd11
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEL_LOGIC = 2'd0, SEL_MUL = 2'd1, SEL_DIV = 2'd2
   } sel_type;

   // sideband that travels with every transaction through the pipe
   typedef struct packed {
      sel_type    sel;
      logic       want_rem;
      logic       neg_q;
      logic       neg_r;
      status_type status;
      logic [DW-1:0] early;
   } side_type;
endpackage

/* sv/integer_alu_64_top.sv */
// Top level: integer ALU with decode, pipelined multiplier and divider
// Every command takes the same path through the pipe from request to response.
// Throughput: one transaction per cycle while not stalled; the divider is 16 stages of 4 bits.
// Stalls freeze the whole pipe; req_ready is combinational in rsp_ready, with no skid buffer.
// Reset: synchronous, active high; clears only the valid bits.
// Logic, shift, rotate, add and subtract results are computed at entry and ride the pipe.
module integer_alu_64_top import ia64_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [3:0]    req_cmd,
   input  logic [63:0]   req_operand_a,
   input  logic [63:0]   req_operand_b,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [63:0]   rsp_result,
   output logic [1:0]    rsp_status
);
   localparam int NS = DIV_STAGES + 1;  // stage 0 is the entry register

   logic adv;
   logic [NS:0] vld_ff;
   logic [NS:0] vld_in;
   side_type side_ff [NS];
   side_type side_in;
   logic [DW-1:0] dvd_ff, dvs_ff, ma_ff, mb_ff;
   logic [DW-1:0] dvd_in, dvs_in;
   logic [DW-1:0] rem_w [DIV_STAGES+1];
   logic [DW-1:0] quo_w [DIV_STAGES+1];
   logic [DW-1:0] dvs_w [DIV_STAGES+1];
   logic [DW-1:0] prod;
   logic [DW-1:0] res_ff, res_in;
   logic [1:0]    st_ff;
   logic [DW-1:0] sel_val, q_s, r_s;
   logic [SW-1:0] amt;
   logic          big;

   // advance the pipe when the output slot is free or being drained
   assign adv = !vld_ff[NS] || rsp_ready;
   assign req_ready = adv;

   // entry decode
   always_comb begin
      side_in = '0;
      side_in.sel = SEL_LOGIC;
      side_in.status = ST_OK;
      amt = req_operand_b[SW-1:0];
      big = |req_operand_b[DW-1:SW];
      dvd_in = req_operand_a[DW-1] ? -req_operand_a : req_operand_a;
      dvs_in = req_operand_b[DW-1] ? -req_operand_b : req_operand_b;
      case (req_cmd)
         CMD_ADD: side_in.early = req_operand_a + req_operand_b;
         CMD_SUB: side_in.early = req_operand_a - req_operand_b;
         CMD_MUL: side_in.sel = SEL_MUL;
         CMD_DIV, CMD_MOD: begin
            if (req_operand_b == '0) begin
               side_in.status = ST_DIV0;
            end else begin
               side_in.sel = SEL_DIV;
               side_in.want_rem = (req_cmd == CMD_MOD);
               side_in.neg_q = req_operand_a[DW-1] ^ req_operand_b[DW-1];
               side_in.neg_r = req_operand_a[DW-1];
            end
         end
         CMD_SHL: side_in.early = big ? '0 : (req_operand_a << amt);
         CMD_SHR: side_in.early = big ? '0 : (req_operand_a >> amt);
         CMD_AND: side_in.early = req_operand_a & req_operand_b;
         CMD_OR:  side_in.early = req_operand_a | req_operand_b;
         CMD_XOR: side_in.early = req_operand_a ^ req_operand_b;
         CMD_ROL: side_in.early = (req_operand_a << amt) |
                     (req_operand_a >> (7'(DW) - {1'b0, amt}));
         CMD_ROR: side_in.early = (req_operand_a >> amt) |
                     (req_operand_a << (7'(DW) - {1'b0, amt}));
         default: side_in.status = ST_INVALID;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (adv) vld_in = {vld_ff[NS-1:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // hold the sideband and operands with their transaction
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < NS; i++) side_ff[i] <= side_ff[i-1];
         dvd_ff <= dvd_in;
         dvs_ff <= dvs_in;
         ma_ff <= req_operand_a;
         mb_ff <= req_operand_b;
         res_ff <= res_in;
         st_ff <= side_ff[NS-1].status;
      end
   end

   ia64_mul u_mul (.clock(clock), .adv(adv), .a(ma_ff), .b(mb_ff), .p(prod));

   // delay the product to line up with the divider output
   logic [DW-1:0] pd_ff [DIV_STAGES-2];
   always_ff @(posedge clock) begin
      if (adv) begin
         pd_ff[0] <= prod;
         for (int i = 1; i < DIV_STAGES-2; i++) pd_ff[i] <= pd_ff[i-1];
      end
   end

   assign rem_w[0] = '0;
   assign quo_w[0] = dvd_ff;
   assign dvs_w[0] = dvs_ff;
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      ia64_div_stage u_stage (
         .clock(clock), .adv(adv),
         .rem_i(rem_w[g]), .quo_i(quo_w[g]), .dvs_i(dvs_w[g]),
         .rem_o(rem_w[g+1]), .quo_o(quo_w[g+1]), .dvs_o(dvs_w[g+1])
      );
   end

   // fix signs and pick the result in the last stage
   always_comb begin
      q_s = side_ff[NS-1].neg_q ? -quo_w[DIV_STAGES] : quo_w[DIV_STAGES];
      r_s = side_ff[NS-1].neg_r ? -rem_w[DIV_STAGES] : rem_w[DIV_STAGES];
      case (side_ff[NS-1].sel)
         SEL_MUL: sel_val = pd_ff[DIV_STAGES-3];
         SEL_DIV: sel_val = side_ff[NS-1].want_rem ? r_s : q_s;
         default: sel_val = side_ff[NS-1].early;
      endcase
      res_in = (side_ff[NS-1].status == ST_OK) ? sel_val : '0;
   end

   assign rsp_valid = vld_ff[NS];
   assign rsp_result = res_ff;
   assign rsp_status = st_ff;
endmodule

/* sv/ia64_mul.sv */
// Pipelined 64x64 low-half multiplier built from 32-bit partial products
module ia64_mul import ia64_pkg::*; (
   input  logic          clock,
   input  logic          adv,
   input  logic [DW-1:0] a,
   input  logic [DW-1:0] b,
   output logic [DW-1:0] p
);
   logic [63:0] ll_ff, lh_ff, hl_ff;
   logic [63:0] ll_in, lh_in, hl_in;
   logic [DW-1:0] p_ff, p_in;

   assign ll_in = 64'(a[31:0]) * 64'(b[31:0]);
   assign lh_in = 64'(a[31:0]) * 64'(b[63:32]);
   assign hl_in = 64'(a[63:32]) * 64'(b[31:0]);
   assign p_in = ll_ff + {lh_ff[31:0] + hl_ff[31:0], 32'd0};
   assign p = p_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         p_ff <= p_in;
      end
   end
endmodule

/* sv/ia64_div_stage.sv */
// One divider stage: retire DIV_STEPS restoring quotient bits
module ia64_div_stage import ia64_pkg::*; (
   input  logic          clock,
   input  logic          adv,
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] quo_i,
   input  logic [DW-1:0] dvs_i,
   output logic [DW-1:0] rem_o,
   output logic [DW-1:0] quo_o,
   output logic [DW-1:0] dvs_o
);
   logic [DW-1:0] rem_ff, quo_ff, dvs_ff;
   logic [DW-1:0] rem_in, quo_in;
   logic [DW:0]   t;

   always_comb begin
      rem_in = rem_i;
      quo_in = quo_i;
      t = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t = {rem_in, quo_in[DW-1]};
         quo_in = {quo_in[DW-2:0], 1'b0};
         if (t >= {1'b0, dvs_i}) begin
            t = t - {1'b0, dvs_i};
            quo_in[0] = 1'b1;
         end
         rem_in = t[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         dvs_ff <= dvs_i;
      end
   end

   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign dvs_o = dvs_ff;
endmodule

/* sv/ia64_checker.sv */
// Checker: port-level properties of the integer ALU
`include "integer_alu_64_top_assert.svh"
module ia64_checker import ia64_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result,
   input logic [1:0]  rsp_status
);
   `ALU_ASSERT_IMP(a_err_zero, rsp_valid && rsp_status != ST_OK, rsp_result == '0, "error with nonzero result")
   `ALU_ASSERT_IMP(a_status_ok, rsp_valid, rsp_status != 2'd3, "bad status code")
   `ALU_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result), "response dropped")
   `ALU_ASSERT_IMP(a_ready_free, !rsp_valid, req_ready, "stalled with empty output")
endmodule

bind integer_alu_64_top ia64_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result(rsp_result),
   .rsp_status(rsp_status)
);
